>>> hw/rtl/sps_pkg.sv
// Package: types, codes and stage table of the staged power rail sequencer.
`timescale 1ns / 1ps

package sps_pkg;

  // Fixed field widths
  localparam int unsigned RailCount   = 10;
  localparam int unsigned SettleBits  = 16;
  localparam int unsigned BoardBits   = 8;
  localparam int unsigned StageBits   = 4;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;

  // Defaults for top-level parameters
  localparam int unsigned WaitBitsDefault = 16;

  // Configuration register indexes and reset values
  localparam logic [CfgIdxBits-1:0] CFG_SETTLE_TICKS = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_BOARD_IDENT  = 2'd1;
  localparam logic [SettleBits-1:0] SettleReset      = 16'd100;
  localparam logic [BoardBits-1:0]  BoardReset       = 8'd0;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_ON   = 2'd1,
    CMD_OFF  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OUT_NONE = 2'd0,
    OUT_OK   = 2'd1,
    OUT_FAIL = 2'd2
  } outcome_e;

  // Stage codes; the numbering is reported in failure events
  typedef enum logic [StageBits-1:0] {
    STG_ASIC_ON     = 4'd0,
    STG_DIMM56_ON   = 4'd1,
    STG_DIMM78_ON   = 4'd2,
    STG_DIMM910_ON  = 4'd3,
    STG_DIMM910_OFF = 4'd4,
    STG_DIMM78_OFF  = 4'd5,
    STG_DIMM56_OFF  = 4'd6,
    STG_RAIL4_OFF   = 4'd7,
    STG_ASIC_OFF    = 4'd8,
    STG_OSC_OFF     = 4'd9,
    STG_OSC_ON      = 4'd10
  } stage_e;

  typedef struct packed {
    logic [1:0]           command;
    logic [RailCount-1:0] power_good;
  } in_word_t;

  typedef struct packed {
    logic [RailCount-1:0] rail_enables;
    logic                 osc_enable;
    logic                 card_pwrok;
    logic                 device_out_of_reset;
    logic                 i2c_enable;
    logic                 powered_on;
    logic                 busy_res;
    logic [1:0]           outcome;
    logic                 event_valid;
    logic                 event_off_fail;
    logic [StageBits-1:0] event_stage;
    logic [BoardBits-1:0] event_board;
  } out_word_t;

  // Rails touched by each stage
  function automatic logic [RailCount-1:0] stage_rails(input logic [StageBits-1:0] s);
    logic [RailCount-1:0] m;
    m = '0;
    unique case (s)
      STG_ASIC_ON:     m = 10'h00F;
      STG_DIMM56_ON:   m = 10'h030;
      STG_DIMM78_ON:   m = 10'h0C0;
      STG_DIMM910_ON:  m = 10'h300;
      STG_DIMM910_OFF: m = 10'h300;
      STG_DIMM78_OFF:  m = 10'h0C0;
      STG_DIMM56_OFF:  m = 10'h030;
      STG_RAIL4_OFF:   m = 10'h008;
      STG_ASIC_OFF:    m = 10'h007;
      default:         m = '0;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/sps_if.sv
// Valid/ready channel interfaces for sequencer input and result words.
`timescale 1ns / 1ps

interface sps_in_if import sps_pkg::*; ;
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sps_out_if import sps_pkg::*; ;
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/staged_power_rail_sequencer.sv
// Staged power rail sequencer: top level with input register, sequencing logic and result register.
`timescale 1ns / 1ps

// Each input word (a time tick or a power-on/off request) is captured in an input
// register, applied to the sequencer state and leaves as one result word through
// an output register. One word is taken every clock cycle while the result side
// keeps up; an accepted word goes from the input register to the result register,
// which holds the pipeline while it is stalled; the input register still takes one
// word while the result waits. Settle times are counted in ticks, not clock cycles:
// after a stage drives its enables, its power-good check happens on the tick that
// finds the wait counter at one or below. The user must write configuration (settle ticks,
// board identifier) only while no sequence or word is in flight; the block does not enforce it.
module staged_power_rail_sequencer import sps_pkg::*; #(
  parameter int unsigned WAIT_BITS = WaitBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  sps_in_if.sink                 in_i,
  sps_out_if.source              out_o
);

  // Configuration registers
  logic [SettleBits-1:0] settle_q;
  logic [BoardBits-1:0]  board_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SettleReset;
      board_q  <= BoardReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SETTLE_TICKS) begin
        settle_q <= cfg_wdata_i[SettleBits-1:0];
      end else if (cfg_idx_i == CFG_BOARD_IDENT) begin
        board_q <= cfg_wdata_i[BoardBits-1:0];
      end
    end
  end

  // Pipeline handshake
  logic     s1_valid_q;
  in_word_t s1_word_q;
  logic     out_valid_q;
  logic     advance;

  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_word_q <= in_i.data;
    end
  end

  // Sequencer state; power-ok, device reset release and I2C enables move together
  logic                 status_q, status_d;
  logic                 active_q, active_d;
  logic                 rolling_q, rolling_d;
  logic [StageBits-1:0] stage_q, stage_d;
  logic [WAIT_BITS-1:0] wait_q, wait_d;
  logic [RailCount-1:0] rails_q, rails_d;
  logic                 osc_q, osc_d;
  logic                 host_ok_q, host_ok_d;

  logic                 enter;
  logic [StageBits-1:0] next_stage;
  logic [RailCount-1:0] chk_mask;
  logic [RailCount-1:0] next_mask;
  outcome_e             outcome;
  logic                 ev;
  logic                 ev_off;

  assign chk_mask  = stage_rails(stage_q);
  assign next_mask = stage_rails(next_stage);

  // Next state for the word in the input register
  always_comb begin
    status_d   = status_q;
    active_d   = active_q;
    rolling_d  = rolling_q;
    stage_d    = stage_q;
    wait_d     = wait_q;
    rails_d    = rails_q;
    osc_d      = osc_q;
    host_ok_d  = host_ok_q;
    enter      = 1'b0;
    next_stage = stage_q;
    outcome    = OUT_NONE;
    ev         = 1'b0;
    ev_off     = 1'b0;

    if (advance) begin
      unique case (s1_word_q.command)
        CMD_ON: begin
          if (!active_q && !status_q) begin
            active_d   = 1'b1;
            rolling_d  = 1'b0;
            enter      = 1'b1;
            next_stage = STG_ASIC_ON;
          end
        end
        CMD_OFF: begin
          if (!active_q && status_q) begin
            host_ok_d  = 1'b0;
            active_d   = 1'b1;
            rolling_d  = 1'b0;
            enter      = 1'b1;
            next_stage = STG_DIMM910_OFF;
          end
        end
        CMD_TICK: begin
          if (active_q) begin
            if (wait_q > WAIT_BITS'(1)) begin
              wait_d = wait_q - WAIT_BITS'(1);
            end else begin
              unique case (stage_q)
                STG_ASIC_ON, STG_DIMM56_ON, STG_DIMM78_ON, STG_DIMM910_ON: begin
                  enter = 1'b1;
                  if ((s1_word_q.power_good & chk_mask) != chk_mask) begin
                    // rail missing: reverse from DIMM910_OFF, or from RAIL4_OFF after ASIC_ON
                    ev         = 1'b1;
                    rolling_d  = 1'b1;
                    next_stage = (stage_q == STG_ASIC_ON) ? STG_RAIL4_OFF
                                                          : STG_DIMM910_OFF;
                  end else if (stage_q == STG_DIMM910_ON) begin
                    next_stage = STG_OSC_ON;
                  end else begin
                    next_stage = stage_q + StageBits'(1);
                  end
                end
                STG_OSC_ON: begin
                  host_ok_d = 1'b1;
                  status_d  = 1'b1;
                  active_d  = 1'b0;
                  outcome   = OUT_OK;
                end
                STG_DIMM910_OFF, STG_DIMM78_OFF, STG_DIMM56_OFF, STG_RAIL4_OFF,
                STG_ASIC_OFF: begin
                  if ((s1_word_q.power_good & chk_mask) != '0) begin
                    // rail still up: stop here
                    ev        = 1'b1;
                    ev_off    = 1'b1;
                    active_d  = 1'b0;
                    rolling_d = 1'b0;
                    outcome   = OUT_FAIL;
                  end else begin
                    enter      = 1'b1;
                    next_stage = (stage_q == STG_ASIC_OFF) ? STG_OSC_OFF
                                                           : stage_q + StageBits'(1);
                  end
                end
                STG_OSC_OFF: begin
                  active_d  = 1'b0;
                  rolling_d = 1'b0;
                  if (rolling_q) begin
                    outcome = OUT_FAIL;
                  end else begin
                    status_d = 1'b0;
                    outcome  = OUT_OK;
                  end
                end
                default: begin
                  active_d  = 1'b0;
                  rolling_d = 1'b0;
                  outcome   = OUT_FAIL;
                end
              endcase
            end
          end
        end
        default: ;
      endcase

      // Stage entry: drive the stage's enables and reload the wait counter
      if (enter) begin
        stage_d = next_stage;
        wait_d  = WAIT_BITS'(settle_q);
        if (next_stage == STG_OSC_ON) begin
          osc_d = 1'b1;
        end else if (next_stage == STG_OSC_OFF) begin
          osc_d = 1'b0;
        end else if (next_stage <= STG_DIMM910_ON) begin
          rails_d = rails_q | next_mask;
        end else begin
          rails_d = rails_q & ~next_mask;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= 1'b0;
      active_q  <= 1'b0;
      rolling_q <= 1'b0;
      stage_q   <= STG_ASIC_ON;
      wait_q    <= '0;
      rails_q   <= '0;
      osc_q     <= 1'b0;
      host_ok_q <= 1'b0;
    end else begin
      status_q  <= status_d;
      active_q  <= active_d;
      rolling_q <= rolling_d;
      stage_q   <= stage_d;
      wait_q    <= wait_d;
      rails_q   <= rails_d;
      osc_q     <= osc_d;
      host_ok_q <= host_ok_d;
    end
  end

  // Result word register
  out_word_t out_word_d;
  out_word_t out_word_q;

  always_comb begin
    out_word_d.rail_enables        = rails_d;
    out_word_d.osc_enable          = osc_d;
    out_word_d.card_pwrok          = host_ok_d;
    out_word_d.device_out_of_reset = host_ok_d;
    out_word_d.i2c_enable          = host_ok_d;
    out_word_d.powered_on          = status_d;
    out_word_d.busy_res            = active_d;
    out_word_d.outcome             = outcome;
    out_word_d.event_valid         = ev;
    out_word_d.event_off_fail      = ev && ev_off;
    out_word_d.event_stage         = ev ? stage_q : '0;
    out_word_d.event_board         = ev ? board_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

endmodule
